FILE: rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Types, codes and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

    // packet type bytes
    localparam logic [7:0] TYPE_LOGIN_ACC = 8'h41;  // 'A'
    localparam logic [7:0] TYPE_LOGIN_REJ = 8'h4A;  // 'J'
    localparam logic [7:0] TYPE_END       = 8'h4F;  // 'O'
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h48;  // 'H'
    localparam logic [7:0] TYPE_SEQ       = 8'h53;  // 'S'
    localparam logic [7:0] TYPE_UNSEQ     = 8'h55;  // 'U'

    localparam logic [7:0]  HB_MSG_TYPE     = 8'd72;
    localparam logic [63:0] START_SEQ_RESET = 64'd1;

    // result kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_HB    = 2'd1;
    localparam logic [1:0] KIND_SEQ   = 2'd2;
    localparam logic [1:0] KIND_UNSEQ = 2'd3;

    typedef enum logic [3:0] {
        PH_LEN_HI = 4'b0001,
        PH_LEN_LO = 4'b0010,
        PH_TYPE   = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        PK_OTHER = 3'd0,
        PK_ACC   = 3'd1,
        PK_REJ   = 3'd2,
        PK_END   = 3'd3,
        PK_HB    = 3'd4,
        PK_SEQ   = 3'd5,
        PK_UNSEQ = 3'd6
    } t_pkind;

    // one classified byte, front to back
    typedef struct packed {
        t_pkind      pk;
        logic        data;      // result carries a data packet record
        logic        has_byte;
        logic [7:0]  byte_val;
        logic [7:0]  mtype;
        logic        finish;    // packet ends on this byte
        logic [63:0] ts;
    } t_op;

    typedef struct packed {
        logic accepted;
        logic rejected;
        logic ended;
    } t_flags;

    typedef struct packed {
        logic [1:0]  kind;
        logic        has_byte;
        logic [7:0]  payload_byte;
        logic        last;
        logic [63:0] sequence_res;
        logic [7:0]  message_type;
        logic [63:0] timestamp;
        t_flags      flags;
    } t_res;

    function automatic t_pkind kind_of_type(input logic [7:0] t);
        t_pkind k;
        unique case (t)
            TYPE_LOGIN_ACC: k = PK_ACC;
            TYPE_LOGIN_REJ: k = PK_REJ;
            TYPE_END:       k = PK_END;
            TYPE_HEARTBEAT: k = PK_HB;
            TYPE_SEQ:       k = PK_SEQ;
            TYPE_UNSEQ:     k = PK_UNSEQ;
            default:        k = PK_OTHER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sbd_if.sv
// ----------------------------------------------------------------------------
// sbd_if
// Valid/ready channels of the deframer: byte input, result output, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [63:0] receive_time;

    modport source (output valid, output data_byte, output receive_time, input ready);
    modport sink   (input valid, input data_byte, input receive_time, output ready);
endinterface

interface sbd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic        last;
    logic [63:0] sequence_res;
    logic [7:0]  message_type;
    logic [63:0] timestamp;
    logic        login_accepted;
    logic        login_rejected;
    logic        session_ended;

    modport source (
        output valid, output kind, output has_byte, output payload_byte, output last,
        output sequence_res, output message_type, output timestamp,
        output login_accepted, output login_rejected, output session_ended,
        input ready
    );
    modport sink (
        input valid, input kind, input has_byte, input payload_byte, input last,
        input sequence_res, input message_type, input timestamp,
        input login_accepted, input login_rejected, input session_ended,
        output ready
    );
endinterface

interface sbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbd_front.sv
// ----------------------------------------------------------------------------
// sbd_front
// Framing parser: tracks length, type and body position per byte and emits
// one classified record per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    sbd_in_if.sink         i_in,
    input  wire            i_full,
    output logic           o_push,
    output sbd_pkg::t_op   o_op
);
    import sbd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_left, n_left;
    t_pkind      r_pk, n_pk;
    logic [7:0]  r_first, n_first;
    logic        r_pending, n_pending;

    logic [7:0]  b;
    logic [15:0] left_dec;
    logic [15:0] len_full;
    t_pkind      tk;
    logic        accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;
    assign b          = i_in.data_byte;
    assign left_dec   = r_left - 16'd1;
    assign len_full   = {r_len_hi, b};
    assign tk         = kind_of_type(b);

    always_comb begin
        n_phase   = r_phase;
        n_len_hi  = r_len_hi;
        n_left    = r_left;
        n_pk      = r_pk;
        n_first   = r_first;
        n_pending = r_pending;

        o_op          = '0;
        o_op.pk       = r_pk;
        o_op.ts       = i_in.receive_time;

        unique case (r_phase)
            PH_LEN_HI: begin
                n_len_hi = b;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_left  = len_full;
                // empty packet: no type byte follows
                n_phase = (len_full == 16'd0) ? PH_LEN_HI : PH_TYPE;
            end
            PH_TYPE: begin
                n_pk      = tk;
                n_left    = left_dec;
                n_first   = 8'd0;
                n_pending = 1'b1;
                o_op.pk   = tk;
                if (left_dec == 16'd0) begin
                    // type-only packet ends here with an empty message
                    o_op.finish = 1'b1;
                    o_op.data   = (tk == PK_SEQ) || (tk == PK_UNSEQ);
                    n_phase     = PH_LEN_HI;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_left = left_dec;
                if (r_pending) begin
                    n_first    = b;
                    n_pending  = 1'b0;
                    o_op.mtype = b;
                end else begin
                    o_op.mtype = r_first;
                end
                o_op.data     = (r_pk == PK_SEQ) || (r_pk == PK_UNSEQ);
                o_op.has_byte = 1'b1;
                o_op.byte_val = b;
                if (left_dec == 16'd0) begin
                    o_op.finish = 1'b1;
                    n_phase     = PH_LEN_HI;
                end
            end
            default: n_phase = PH_LEN_HI;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN_HI;
            r_len_hi  <= 8'd0;
            r_left    <= 16'd0;
            r_pk      <= PK_OTHER;
            r_first   <= 8'd0;
            r_pending <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_len_hi  <= n_len_hi;
            r_left    <= n_left;
            r_pk      <= n_pk;
            r_first   <= n_first;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbd_queue.sv
// ----------------------------------------------------------------------------
// sbd_queue
// Small register FIFO of classified records between parser and formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_queue #(
    parameter int DEPTH = 2
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  sbd_pkg::t_op   i_data,
    output logic           o_full,
    output logic           o_valid,
    output sbd_pkg::t_op   o_data,
    input  wire            i_pop
);
    import sbd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbd_back.sv
// ----------------------------------------------------------------------------
// sbd_back
// Result formatter: applies packet-end effects (sequence, status flags) and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  sbd_pkg::t_op   i_op,
    output logic           o_pop,
    input  wire            i_seq_we,
    input  wire [63:0]     i_seq_data,
    sbd_out_if.source      o_out
);
    import sbd_pkg::*;

    logic        r_valid;
    t_res        r_res, n_res;
    logic [63:0] r_seq, n_seq;
    t_flags      r_flags, n_flags;
    logic        is_seq, is_hb;

    assign o_pop  = i_valid && (!r_valid || o_out.ready);
    assign is_seq = (i_op.pk == PK_SEQ);
    assign is_hb  = i_op.finish && (i_op.pk == PK_HB);

    always_comb begin
        n_seq   = r_seq;
        n_flags = r_flags;
        if (i_op.finish) begin
            case (i_op.pk)
                PK_ACC:  n_flags.accepted = 1'b1;
                PK_REJ:  n_flags.rejected = 1'b1;
                PK_END:  n_flags.ended    = 1'b1;
                PK_SEQ:  n_seq            = r_seq + 64'd1;
                default: ;
            endcase
        end

        n_res           = '0;
        n_res.timestamp = i_op.ts;
        n_res.flags     = n_flags;
        n_res.last      = i_op.finish &&
                          ((i_op.pk == PK_HB) || (i_op.pk == PK_SEQ) || (i_op.pk == PK_UNSEQ));
        if (i_op.data) begin
            n_res.kind         = is_seq ? KIND_SEQ : KIND_UNSEQ;
            n_res.has_byte     = i_op.has_byte;
            n_res.payload_byte = i_op.has_byte ? i_op.byte_val : 8'd0;
            n_res.sequence_res = is_seq ? r_seq : 64'd0;
            n_res.message_type = i_op.mtype;
        end else if (is_hb) begin
            n_res.kind         = KIND_HB;
            n_res.message_type = HB_MSG_TYPE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seq   <= START_SEQ_RESET;
            r_flags <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_seq   <= n_seq;
                r_flags <= n_flags;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            // the user must write config only while idle; the block does not enforce it
            if (i_seq_we) begin
                r_seq <= i_seq_data;
            end
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_res.kind;
    assign o_out.has_byte       = r_res.has_byte;
    assign o_out.payload_byte   = r_res.payload_byte;
    assign o_out.last           = r_res.last;
    assign o_out.sequence_res   = r_res.sequence_res;
    assign o_out.message_type   = r_res.message_type;
    assign o_out.timestamp      = r_res.timestamp;
    assign o_out.login_accepted = r_res.flags.accepted;
    assign o_out.login_rejected = r_res.flags.rejected;
    assign o_out.session_ended  = r_res.flags.ended;

endmodule

`default_nettype wire

FILE: rtl/soupbintcp_packet_deframer.sv
// ----------------------------------------------------------------------------
// soupbintcp_packet_deframer
// Session stream deframer: one raw byte in, one result record out.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while the queue has room and returns
// exactly one result per byte, in order, carrying that byte's receive time.
// Sustained rate is one byte per clock while the sink stays ready, set by
// the parser's state update and the formatter's output register. Records pass
// the queue, then the output register. The input side keeps taking bytes
// while results wait, until the QUEUE_DEPTH-entry queue and the output
// register are full. start_sequence is written through i_cfg (always ready)
// and loads the running sequence at once; write it only while no bytes are
// in flight. Status flags are sticky until reset.
`default_nettype none

module soupbintcp_packet_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sbd_in_if.sink      i_in,
    sbd_cfg_if.sink     i_cfg,
    sbd_out_if.source   o_out
);
    import sbd_pkg::*;

    logic full, push, q_valid, pop;
    t_op  op_in, op_out;

    assign i_cfg.ready = 1'b1;

    sbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_op    (op_in)
    );

    sbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (op_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (op_out),
        .i_pop   (pop)
    );

    sbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_op       (op_out),
        .o_pop      (pop),
        .i_seq_we   (i_cfg.valid),
        .i_seq_data (i_cfg.data),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the session stream deframer.
// ----------------------------------------------------------------------------
// Feeds framed packets one byte per transfer and predicts every result record
// in-bench. Results are compared field by field, in order. Covers empty and
// one-byte packets, all packet types, long lengths, start-sequence writes with
// wrap, and random traffic with idling and sink back-pressure on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbd_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_BYTES = 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sbd_in_if  in_ch ();
    sbd_out_if out_ch ();
    sbd_cfg_if cfg_ch ();

    soupbintcp_packet_deframer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // deframer state as predicted by the bench
    t_phase      parse_phase   = PH_LEN_HI;
    logic [7:0]  len_high      = '0;
    logic [15:0] bytes_left    = '0;
    t_pkind      pkt_kind      = PK_OTHER;
    logic [7:0]  first_byte    = '0;
    logic        first_pending = 1'b0;
    logic [63:0] next_seq      = START_SEQ_RESET;
    t_flags      session_flags = '0;

    t_res        expected_q[$];

    int unsigned items_sent      = 0;
    int unsigned packets_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned seq_writes      = 0;
    int unsigned errors          = 0;
    int unsigned quiet_cycles    = 0;

    bit   steady    = 1'b0;  // no idling on either side
    bit   sink_hold = 1'b0;
    event hold_off;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic void close_packet(inout t_res r);
        case (pkt_kind)
            PK_ACC: session_flags.accepted = 1'b1;
            PK_REJ: session_flags.rejected = 1'b1;
            PK_END: session_flags.ended = 1'b1;
            PK_HB: begin
                r.kind         = KIND_HB;
                r.last         = 1'b1;
                r.message_type = HB_MSG_TYPE;
            end
            PK_SEQ: begin
                r.last   = 1'b1;
                next_seq = next_seq + 64'd1;
            end
            PK_UNSEQ: r.last = 1'b1;
            default: ;
        endcase
        parse_phase = PH_LEN_HI;
    endfunction

    function automatic t_res deframe_byte(input logic [7:0] b, input logic [63:0] ts);
        t_res r;
        r           = '0;
        r.timestamp = ts;
        case (parse_phase)
            PH_LEN_HI: begin
                len_high    = b;
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                bytes_left  = {len_high, b};
                parse_phase = (bytes_left == 16'd0) ? PH_LEN_HI : PH_TYPE;
            end
            PH_TYPE: begin
                case (b)
                    TYPE_LOGIN_ACC: pkt_kind = PK_ACC;
                    TYPE_LOGIN_REJ: pkt_kind = PK_REJ;
                    TYPE_END:       pkt_kind = PK_END;
                    TYPE_HEARTBEAT: pkt_kind = PK_HB;
                    TYPE_SEQ:       pkt_kind = PK_SEQ;
                    TYPE_UNSEQ:     pkt_kind = PK_UNSEQ;
                    default:        pkt_kind = PK_OTHER;
                endcase
                bytes_left    = bytes_left - 16'd1;
                first_byte    = '0;
                first_pending = 1'b1;
                if (bytes_left == 16'd0) begin
                    // one-byte packet: data packets still emit an empty record
                    if (pkt_kind == PK_SEQ) begin
                        r.kind         = KIND_SEQ;
                        r.sequence_res = next_seq;
                    end else if (pkt_kind == PK_UNSEQ) begin
                        r.kind = KIND_UNSEQ;
                    end
                    close_packet(r);
                end else begin
                    parse_phase = PH_BODY;
                end
            end
            default: begin
                bytes_left = bytes_left - 16'd1;
                if (first_pending) begin
                    first_byte    = b;
                    first_pending = 1'b0;
                end
                if (pkt_kind == PK_SEQ || pkt_kind == PK_UNSEQ) begin
                    r.kind         = (pkt_kind == PK_SEQ) ? KIND_SEQ : KIND_UNSEQ;
                    r.has_byte     = 1'b1;
                    r.payload_byte = b;
                    r.message_type = first_byte;
                    if (pkt_kind == PK_SEQ)
                        r.sequence_res = next_seq;
                end
                if (bytes_left == 16'd0)
                    close_packet(r);
            end
        endcase
        r.flags = session_flags;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand_ts();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] unknown_type();
        logic [7:0] t;
        do t = 8'($urandom);
        while (t inside {TYPE_LOGIN_ACC, TYPE_LOGIN_REJ, TYPE_END,
                         TYPE_HEARTBEAT, TYPE_SEQ, TYPE_UNSEQ});
        return t;
    endfunction

    // valid stays high after a transfer; a drain, or idling in the next call, lowers it
    task automatic send_byte(input logic [7:0] b, input logic [63:0] ts);
        if (!steady) begin
            while ($urandom_range(99) < 38) begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.receive_time <= ts;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_q.push_back(deframe_byte(b, ts));
        items_sent++;
    endtask

    task automatic send_packet(input logic [7:0] ptype, input int unsigned body_len);
        logic [15:0] len;
        len = 16'(body_len + 1);
        send_byte(len[15:8], rand_ts());
        send_byte(len[7:0], rand_ts());
        send_byte(ptype, rand_ts());
        repeat (body_len) send_byte(8'($urandom), rand_ts());
        packets_sent++;
    endtask

    task automatic send_random_packet(input bit with_session);
        int unsigned pick;
        pick = $urandom_range(99);
        if (with_session && pick < 12) begin
            send_packet((pick < 4) ? TYPE_LOGIN_ACC :
                        (pick < 8) ? TYPE_LOGIN_REJ : TYPE_END, $urandom_range(3));
        end else if (pick < 45) begin
            send_packet(TYPE_SEQ, $urandom_range(12));
        end else if (pick < 75) begin
            send_packet(TYPE_UNSEQ, $urandom_range(12));
        end else if (pick < 85) begin
            send_packet(TYPE_HEARTBEAT, $urandom_range(2));
        end else if (pick < 94) begin
            send_packet(unknown_type(), $urandom_range(6));
        end else begin
            // empty packet: just a zero length
            send_byte(8'h00, rand_ts());
            send_byte(8'h00, rand_ts());
            packets_sent++;
        end
    endtask

    // always waits on the clock before returning
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    task automatic load_start_sequence(input logic [63:0] value);
        wait_for_drain();
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        next_seq      = value;
        seq_writes++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_framing_directed();
        logic [7:0] stream[$];
        stream = {8'h00, 8'h00,                               // empty packet
                  8'h00, 8'h01, TYPE_SEQ,                     // sequenced, no payload
                  8'h00, 8'h03, TYPE_UNSEQ, 8'hFF, 8'h00,
                  8'h00, 8'h01, TYPE_HEARTBEAT,
                  8'h00, 8'h02, TYPE_HEARTBEAT, 8'h5A,        // payload ignored
                  8'h00, 8'h02, 8'h5A, 8'h11,                 // unknown type
                  8'h00, 8'h03, TYPE_SEQ, 8'h00, 8'hFF};
        foreach (stream[i])
            send_byte(stream[i], (i == 0) ? 64'd0 : (i == 1) ? '1 : rand_ts());
        packets_sent += 7;
    endtask

    task automatic test_start_sequence();
        load_start_sequence(64'd0);
        send_packet(TYPE_SEQ, 0);
        send_packet(TYPE_SEQ, 3);
        send_packet(TYPE_UNSEQ, 2);
        load_start_sequence('1);   // wraps to zero after one packet
        send_packet(TYPE_SEQ, 2);
        send_packet(TYPE_SEQ, 1);
        load_start_sequence(rand_ts());
        repeat (3) send_packet(TYPE_SEQ, $urandom_range(4));
    endtask

    task automatic test_long_lengths();
        steady = 1'b1;
        send_packet(TYPE_SEQ, 255);   // length 0x0100, high byte in use
        steady = 1'b0;
    endtask

    task automatic test_random_stream();
        int unsigned first_item;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_BYTES) begin
            steady = (items_sent - first_item > 30) && (items_sent - first_item < 70);
            send_random_packet(1'b0);
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        int unsigned first_item;
        first_item = items_sent;
        steady = 1'b1;
        -> hold_off;
        while (items_sent - first_item < 40) send_random_packet(1'b0);
        steady = 1'b0;
        // sender pauses until everything has come out
        wait_for_drain();
        repeat (3) send_random_packet(1'b0);
    endtask

    task automatic test_session_flags();
        load_start_sequence(rand_ts());
        send_packet(TYPE_LOGIN_REJ, 0);
        repeat (3) send_random_packet(1'b0);
        send_packet(TYPE_END, 2);
        repeat (3) send_random_packet(1'b0);
        send_packet(TYPE_LOGIN_ACC, 1);
        repeat (4) send_random_packet(1'b1);
    endtask

    // ------------------------------------------------------------------------
    // sink side, checking, watchdog
    // ------------------------------------------------------------------------
    always begin
        @(hold_off);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    always @(posedge clk)
        out_ch.ready <= !sink_hold && (steady || $urandom_range(99) >= 38);

    task automatic report_mismatch(input string what);
        if (errors < 40)
            $display("MISMATCH result %0d: %s", results_checked, what);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk) begin
        t_res want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = expected_q.pop_front();
                check_field("kind", out_ch.kind, want.kind);
                check_field("has_byte", out_ch.has_byte, want.has_byte);
                check_field("payload_byte", out_ch.payload_byte, want.payload_byte);
                check_field("last", out_ch.last, want.last);
                check_field("sequence_res", out_ch.sequence_res, want.sequence_res);
                check_field("message_type", out_ch.message_type, want.message_type);
                check_field("timestamp", out_ch.timestamp, want.timestamp);
                check_field("login_accepted", out_ch.login_accepted, want.flags.accepted);
                check_field("login_rejected", out_ch.login_rejected, want.flags.rejected);
                check_field("session_ended", out_ch.session_ended, want.flags.ended);
            end
            results_checked++;
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.receive_time = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_framing_directed();
        test_start_sequence();
        test_long_lengths();
        test_random_stream();
        test_backpressure();
        test_session_flags();

        wait_for_drain();
        repeat (6) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        $display("covered: %0d stream bytes in %0d packets, %0d results checked",
                 items_sent, packets_sent, results_checked);
        $display("covered: %0d start-sequence writes incl. zero and all-ones, sink hold",
                 seq_writes);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
